FILE: hw/rtl/comf_pkg.sv
// Shared types and constants for the clock offset minimum filter.
// Holds the transaction structs, command codes, sequencer states and divider sizing.
// No dependencies.
package comf_pkg;

    // One input transaction.
    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        remote_time_us;
        logic signed [63:0] host_time_ns;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic signed [63:0] mapped_host_ns;
        logic [31:0]        mapped_remote_us;
        logic               answer_valid;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_SYNC      = 2'd0,
        CMD_TO_HOST   = 2'd1,
        CMD_TO_REMOTE = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UNWRAP,
        ST_MUL,
        ST_CAND,
        ST_FILL,
        ST_RD_ACT,
        ST_CMP_ACT,
        ST_ROTATE,
        ST_SCAN,
        ST_HOST_OUT,
        ST_DIV_PREP,
        ST_DIV,
        ST_DIV_END,
        ST_FINISH
    } state_t;

    localparam int unsigned CFG_W         = 40;
    localparam logic [CFG_W-1:0] DURATION_RESET = 40'd1000000000;

    localparam int unsigned US_TO_NS      = 1000;
    localparam int unsigned REM_W         = 10;
    localparam int unsigned DIV_DIGITS    = 4;
    localparam int unsigned DIV_STEPS     = 64 / DIV_DIGITS;
    localparam int unsigned DIV_CNT_W     = $clog2(DIV_STEPS);

endpackage

FILE: hw/rtl/comf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the bucket minimum store; no package dependencies.
module comf_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/clock_offset_min_filter.sv
// Top level of the clock offset minimum filter.
// Depends on comf_pkg (types, states, constants) and comf_ram (bucket store).
//
// Usage:
// The block relates a wrapping 32-bit microsecond remote clock to a 64-bit
// nanosecond host clock. Each input transaction on in_valid/in_ready carries a
// command: a sync sample, a remote-to-host mapping or a host-to-remote mapping.
// Every input transaction yields exactly one result transaction on
// out_valid/out_ready. The bucket duration is written through the cfg channel,
// which is always ready; write it only while the block is idle.
//
// Operation: the block works on one transaction at a time. A sync scans the bucket
// memory through its single read port; a restart or first sync instead fills the
// memory. A host-to-remote map runs in the divide-by-1000 unit, which retires four
// quotient bits per cycle over a 64-bit magnitude. Once a result moves to the output
// register, the block returns to idle and is ready for the next transaction.
//
// Reset clears the unwrapping state, the ring position and the offset; the
// bucket memory holds no reset value and is filled on the first sync. A finished
// result sits in the output register until taken, and the block accepts the
// next transaction meanwhile; it stalls only when a second result is ready
// before the first has been taken.
module clock_offset_min_filter #(
    parameter int unsigned NUM_BUCKETS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  comf_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output comf_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [comf_pkg::CFG_W-1:0]      cfg_data
);

    // Address width of the bucket store and width of a counter that reaches its depth.
    localparam int unsigned AW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int unsigned CW = $clog2(NUM_BUCKETS + 1);

    comf_pkg::state_t state_reg, state_next;

    // Control state.
    logic [comf_pkg::CFG_W-1:0]            duration_reg;
    logic                                  started_reg;
    logic [31:0]                           prev_remote_reg;
    logic [31:0]                           epoch_hi_reg;
    logic [AW-1:0]                         active_reg;
    logic [63:0]                           start_ns_reg;
    logic [63:0]                           offset_reg;
    logic                                  init_reg;
    logic [CW-1:0]                         cnt_reg;
    logic                                  scan_pend_reg;
    logic                                  scan_first_reg;
    logic [comf_pkg::DIV_CNT_W-1:0]        div_cnt_reg;
    logic                                  out_valid_reg;

    // Payload registers.
    logic [1:0]                            cmd_reg;
    logic [31:0]                           rem_in_reg;
    logic [63:0]                           host_reg;
    logic [63:0]                           unwrapped_reg;
    logic [63:0]                           prod_reg;
    logic [63:0]                           cand_reg;
    logic [63:0]                           min_reg;
    logic [63:0]                           dvd_reg;
    logic [comf_pkg::REM_W-1:0]            div_rem_reg;
    logic [31:0]                           quot_reg;
    logic                                  neg_reg;
    comf_pkg::out_item_t                   res_reg;
    comf_pkg::out_item_t                   out_reg;

    // Bucket store port.
    logic                                  ram_we;
    logic [AW-1:0]                         ram_waddr;
    logic [63:0]                           ram_wdata;
    logic [AW-1:0]                         ram_raddr;
    logic [63:0]                           ram_rdata;

    // Datapath helpers.
    logic [31:0]                           back_jump;
    logic                                  wrapped;
    logic                                  restart;
    logic [31:0]                           epoch_hi_next;
    logic [63:0]                           since_start;
    logic                                  rotate;
    logic [AW-1:0]                         active_next;
    logic                                  last_bucket;
    logic                                  out_free;
    logic [comf_pkg::REM_W-1:0]            div_rem_next;
    logic [comf_pkg::DIV_DIGITS-1:0]       div_q_digits;
    logic [comf_pkg::REM_W:0]              div_trial;

    comf_ram #(
        .WIDTH (64),
        .DEPTH (NUM_BUCKETS)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == comf_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Unwrapping: a backward jump of at least half the range is a wrap, a smaller one a restart.
    assign back_jump = prev_remote_reg - rem_in_reg;
    assign wrapped   = started_reg && (rem_in_reg < prev_remote_reg) && back_jump[31];
    assign restart   = started_reg && (rem_in_reg < prev_remote_reg) && !back_jump[31];

    always_comb
    begin
        if (!started_reg || restart)
        begin
            epoch_hi_next = 32'd0;
        end
        else if (wrapped)
        begin
            epoch_hi_next = epoch_hi_reg + 32'd1;
        end
        else
        begin
            epoch_hi_next = epoch_hi_reg;
        end
    end

    // The ring advances once the active bucket has been open longer than the duration.
    assign since_start = host_reg - start_ns_reg;
    assign rotate      = $signed(since_start) > $signed({24'd0, duration_reg});
    assign last_bucket = (active_reg == AW'(NUM_BUCKETS - 1));
    assign active_next = last_bucket ? '0 : active_reg + AW'(1);

    // Divide-by-1000 step: four restoring digits on the running remainder.
    always_comb
    begin
        div_rem_next = div_rem_reg;
        div_q_digits = '0;
        div_trial    = '0;
        for (int k = 0; k < comf_pkg::DIV_DIGITS; k++)
        begin
            div_trial = {div_rem_next, dvd_reg[63 - k]};
            if (div_trial >= (comf_pkg::REM_W + 1)'(comf_pkg::US_TO_NS))
            begin
                div_trial = div_trial - (comf_pkg::REM_W + 1)'(comf_pkg::US_TO_NS);
                div_q_digits[comf_pkg::DIV_DIGITS - 1 - k] = 1'b1;
            end
            div_rem_next = div_trial[comf_pkg::REM_W-1:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            comf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = comf_pkg::ST_UNWRAP;
                end
            end
            comf_pkg::ST_UNWRAP:
            begin
                case (cmd_reg)
                    comf_pkg::CMD_SYNC:      state_next = comf_pkg::ST_MUL;
                    comf_pkg::CMD_TO_HOST:
                        state_next = started_reg ? comf_pkg::ST_MUL : comf_pkg::ST_FINISH;
                    comf_pkg::CMD_TO_REMOTE:
                        state_next = started_reg ? comf_pkg::ST_DIV_PREP : comf_pkg::ST_FINISH;
                    default:                 state_next = comf_pkg::ST_FINISH;
                endcase
            end
            comf_pkg::ST_MUL:
            begin
                if (cmd_reg == comf_pkg::CMD_SYNC)
                begin
                    state_next = comf_pkg::ST_CAND;
                end
                else
                begin
                    state_next = comf_pkg::ST_HOST_OUT;
                end
            end
            comf_pkg::ST_CAND:
            begin
                if (init_reg)
                begin
                    state_next = comf_pkg::ST_FILL;
                end
                else if (rotate)
                begin
                    state_next = comf_pkg::ST_ROTATE;
                end
                else
                begin
                    state_next = comf_pkg::ST_RD_ACT;
                end
            end
            comf_pkg::ST_FILL:
            begin
                if (cnt_reg == CW'(NUM_BUCKETS - 1))
                begin
                    state_next = comf_pkg::ST_HOST_OUT;
                end
            end
            comf_pkg::ST_RD_ACT:   state_next = comf_pkg::ST_CMP_ACT;
            comf_pkg::ST_CMP_ACT:  state_next = comf_pkg::ST_SCAN;
            comf_pkg::ST_ROTATE:   state_next = comf_pkg::ST_SCAN;
            comf_pkg::ST_SCAN:
            begin
                if ((cnt_reg == CW'(NUM_BUCKETS)) && scan_pend_reg)
                begin
                    state_next = comf_pkg::ST_HOST_OUT;
                end
            end
            comf_pkg::ST_HOST_OUT: state_next = comf_pkg::ST_FINISH;
            comf_pkg::ST_DIV_PREP: state_next = comf_pkg::ST_DIV;
            comf_pkg::ST_DIV:
            begin
                if (div_cnt_reg == comf_pkg::DIV_CNT_W'(comf_pkg::DIV_STEPS - 1))
                begin
                    state_next = comf_pkg::ST_DIV_END;
                end
            end
            comf_pkg::ST_DIV_END:  state_next = comf_pkg::ST_FINISH;
            comf_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = comf_pkg::ST_IDLE;
                end
            end
            default:               state_next = comf_pkg::ST_IDLE;
        endcase
    end

    // Bucket store controls.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = active_reg;
        ram_wdata = cand_reg;
        ram_raddr = active_reg;
        unique case (state_reg)
            comf_pkg::ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
            end
            comf_pkg::ST_ROTATE:
            begin
                ram_we    = 1'b1;
                ram_waddr = active_next;
            end
            comf_pkg::ST_CMP_ACT:
            begin
                ram_we = $signed(cand_reg) < $signed(ram_rdata);
            end
            comf_pkg::ST_SCAN:
            begin
                ram_raddr = cnt_reg[AW-1:0];
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= comf_pkg::ST_IDLE;
            duration_reg    <= comf_pkg::DURATION_RESET;
            started_reg     <= 1'b0;
            prev_remote_reg <= '0;
            epoch_hi_reg    <= '0;
            active_reg      <= '0;
            start_ns_reg    <= '0;
            offset_reg      <= '0;
            init_reg        <= 1'b0;
            cnt_reg         <= '0;
            scan_pend_reg   <= 1'b0;
            scan_first_reg  <= 1'b0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                duration_reg <= cfg_data;
            end
            // A new result enters the output register when it is empty or as the old one leaves.
            if ((state_reg == comf_pkg::ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                comf_pkg::ST_UNWRAP:
                begin
                    if (cmd_reg == comf_pkg::CMD_SYNC)
                    begin
                        prev_remote_reg <= rem_in_reg;
                        epoch_hi_reg    <= epoch_hi_next;
                        init_reg        <= !started_reg || restart;
                    end
                end
                comf_pkg::ST_CAND:
                begin
                    cnt_reg        <= '0;
                    scan_pend_reg  <= 1'b0;
                    scan_first_reg <= 1'b1;
                end
                comf_pkg::ST_FILL:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(NUM_BUCKETS - 1))
                    begin
                        start_ns_reg <= host_reg;
                        started_reg  <= 1'b1;
                    end
                end
                comf_pkg::ST_ROTATE:
                begin
                    active_reg   <= active_next;
                    start_ns_reg <= host_reg;
                end
                comf_pkg::ST_SCAN:
                begin
                    if (cnt_reg != CW'(NUM_BUCKETS))
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    scan_pend_reg <= (cnt_reg != CW'(NUM_BUCKETS));
                    if (scan_pend_reg)
                    begin
                        scan_first_reg <= 1'b0;
                    end
                end
                comf_pkg::ST_HOST_OUT:
                begin
                    offset_reg <= min_reg;
                end
                comf_pkg::ST_DIV_PREP:
                begin
                    div_cnt_reg <= '0;
                end
                comf_pkg::ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + comf_pkg::DIV_CNT_W'(1);
                end
                default:
                begin
                    init_reg <= init_reg;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            comf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_reg    <= in_data.command;
                    rem_in_reg <= in_data.remote_time_us;
                    host_reg   <= in_data.host_time_ns;
                end
            end
            comf_pkg::ST_UNWRAP:
            begin
                // Results that carry no answer are all zero.
                res_reg <= '0;
                if (cmd_reg == comf_pkg::CMD_SYNC)
                begin
                    unwrapped_reg <= {epoch_hi_next, rem_in_reg};
                end
                else
                begin
                    unwrapped_reg <= {epoch_hi_reg, rem_in_reg};
                end
                min_reg <= offset_reg;
                dvd_reg <= host_reg - offset_reg;
            end
            comf_pkg::ST_MUL:
            begin
                // Times 1000 as 1024 - 16 - 8.
                prod_reg <= {unwrapped_reg[53:0], 10'd0} - {unwrapped_reg[59:0], 4'd0}
                            - {unwrapped_reg[60:0], 3'd0};
            end
            comf_pkg::ST_CAND:
            begin
                cand_reg <= host_reg - prod_reg;
            end
            comf_pkg::ST_FILL:
            begin
                min_reg <= cand_reg;
            end
            comf_pkg::ST_SCAN:
            begin
                if (scan_pend_reg && (scan_first_reg || ($signed(ram_rdata) < $signed(min_reg))))
                begin
                    min_reg <= ram_rdata;
                end
            end
            comf_pkg::ST_HOST_OUT:
            begin
                res_reg.mapped_host_ns   <= prod_reg + min_reg;
                res_reg.mapped_remote_us <= '0;
                res_reg.answer_valid     <= 1'b1;
            end
            comf_pkg::ST_DIV_PREP:
            begin
                neg_reg     <= dvd_reg[63];
                dvd_reg     <= dvd_reg[63] ? (64'd0 - dvd_reg) : dvd_reg;
                div_rem_reg <= '0;
                quot_reg    <= '0;
            end
            comf_pkg::ST_DIV:
            begin
                div_rem_reg <= div_rem_next;
                dvd_reg     <= {dvd_reg[63-comf_pkg::DIV_DIGITS:0], {comf_pkg::DIV_DIGITS{1'b0}}};
                quot_reg    <= {quot_reg[31-comf_pkg::DIV_DIGITS:0], div_q_digits};
            end
            comf_pkg::ST_DIV_END:
            begin
                res_reg.mapped_host_ns   <= '0;
                res_reg.mapped_remote_us <= neg_reg ? (32'd0 - quot_reg) : quot_reg;
                res_reg.answer_valid     <= 1'b1;
            end
            comf_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_reg <= res_reg;
                end
            end
            default:
            begin
                cand_reg <= cand_reg;
            end
        endcase
    end

endmodule
